/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers for the volume normalizer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising clk edge outside reset
`define AVN_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that a condition implies another in the same cycle
`define AVN_ASSERT_IMPL(lbl, ante, cons, msg) \
	`AVN_ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/core/avn_pkg.sv */
// ----------------------------------------------------------------------------
// avn_pkg
// Shared constants and types of the audio volume normalizer.
// ----------------------------------------------------------------------------
package avn_pkg;

	localparam int HIST_DEPTH = 20;
	localparam int MAX_CH     = 8;

	localparam int CH_W    = $clog2(MAX_CH);
	localparam int CNT_W   = $clog2(MAX_CH + 1);
	localparam int SLOT_W  = $clog2(HIST_DEPTH);
	localparam int HIST_AW = $clog2(MAX_CH * HIST_DEPTH);
	localparam int HIST_N  = MAX_CH * HIST_DEPTH;

	localparam int SUM_W   = 60;
	localparam int TOT_W   = 29;
	localparam int LVL_W   = 24;
	localparam int GAIN_W  = 24;

	localparam int SQ_IN_W  = 46;
	localparam int SQ_OUT_W = 23;

	localparam int DIVD_W = 64;
	localparam int DIVS_W = 45;
	localparam int QUO_W  = 32;

	localparam logic [GAIN_W-1:0] UNITY_Q16 = 24'd65536;
	localparam logic [GAIN_W-1:0] GAIN_MAX  = 24'hFFFFFF;
	localparam logic [23:0]       MIN_LEVEL = 24'd655;
	localparam logic [6:0]        VOL_MAX   = 7'd100;
	localparam logic [15:0]       AMP_MAX   = 16'd40960;
	localparam logic [18:0]       DEN_SCALE = 19'd409600;
	localparam logic [31:0]       RECIP5    = 32'hCCCCCCCD;

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MUTE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_NORMALIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEVEL = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_CH_COUNT  = 3'd5;

	typedef struct packed {
		logic [SUM_W-1:0]  sum;
		logic [TOT_W-1:0]  tot;
		logic [GAIN_W-1:0] gain;
	} chan_entry_t;

	localparam int CHAN_W = $bits(chan_entry_t);

endpackage

/* rtl/core/avn_ram.sv */
// ----------------------------------------------------------------------------
// avn_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module avn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/core/avn_sqrt.sv */
// ----------------------------------------------------------------------------
// avn_sqrt
// Iterative integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module avn_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [avn_pkg::SQ_IN_W-1:0]  radicand,
	output logic                         done,
	output logic [avn_pkg::SQ_OUT_W-1:0] root
);

	localparam int REM_W = avn_pkg::SQ_OUT_W + 3;
	localparam int CW    = $clog2(avn_pkg::SQ_OUT_W);

	logic [avn_pkg::SQ_IN_W-1:0]  x_q;
	logic [avn_pkg::SQ_OUT_W-1:0] r_q;
	logic [REM_W-1:0]             rem_q;
	logic [CW-1:0]                cnt_q;
	logic                         run_q;
	logic                         done_q;
	logic [REM_W-1:0]             rem_sh;
	logic [REM_W-1:0]             trial;
	logic                         ge;

	assign rem_sh = {rem_q[REM_W-3:0], x_q[avn_pkg::SQ_IN_W-1 -: 2]};
	assign trial  = {1'b0, r_q, 2'b01};
	assign ge     = rem_sh >= trial;
	assign done   = done_q;
	assign root   = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				x_q   <= radicand;
				r_q   <= '0;
				rem_q <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				x_q   <= {x_q[avn_pkg::SQ_IN_W-3:0], 2'b00};
				rem_q <= ge ? rem_sh - trial : rem_sh;
				r_q   <= {r_q[avn_pkg::SQ_OUT_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(avn_pkg::SQ_OUT_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/avn_div.sv */
// ----------------------------------------------------------------------------
// avn_div
// Restoring divider, one quotient bit per cycle; the quotient must fit.
// ----------------------------------------------------------------------------
module avn_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [avn_pkg::DIVD_W-1:0] dividend,
	input  logic [avn_pkg::DIVS_W-1:0] divisor,
	output logic                       done,
	output logic [avn_pkg::QUO_W-1:0]  quotient
);

	localparam int QW = avn_pkg::QUO_W;
	localparam int SW = avn_pkg::DIVS_W;
	localparam int CW = $clog2(QW);

	logic [SW-1:0] rem_q;
	logic [SW-1:0] dvs_q;
	logic [QW-1:0] lo_q;
	logic [QW-1:0] q_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [SW:0]   t;
	logic          ge;

	assign t        = {rem_q, lo_q[QW-1]};
	assign ge       = t >= {1'b0, dvs_q};
	assign done     = done_q;
	assign quotient = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q <= SW'(dividend[avn_pkg::DIVD_W-1:QW]);
				lo_q  <= dividend[QW-1:0];
				dvs_q <= divisor;
				q_q   <= '0;
				cnt_q <= '0;
				run_q <= 1'b1;
			end else if (run_q) begin
				rem_q <= ge ? SW'(t - {1'b0, dvs_q}) : SW'(t);
				lo_q  <= {lo_q[QW-2:0], 1'b0};
				q_q   <= {q_q[QW-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* rtl/core/audio_volume_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// audio_volume_normalizer_unit
// Volume, preamp, mute and power-history loudness normalization, Q1.23 audio.
// ----------------------------------------------------------------------------
// After reset the block clears its level history memory and holds busy high.
// A measure request produces nothing; with buffer_end set, normalization on
// and mute off, it then closes the buffer, one active channel after another
// (23-step square root, plus the gain divide when the average exceeds the
// limit). An apply request uses the 32-step shared divider and ends in a
// one-cycle done strobe with the result; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module audio_volume_normalizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [2:0]                    channel,
	input  logic signed [23:0]            sample_in,
	input  logic                          buffer_end,
	output logic                          done,
	output logic signed [23:0]            sample_out,
	output logic [2:0]                    channel_out,
	output logic                          clipped,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [avn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [23:0]                   cfg_data
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_M_RD, S_M_ADD,
		S_C_RD, S_C_LOAD, S_C_SQ, S_C_TOT, S_C_AVG, S_C_CMP, S_C_DIV, S_C_WR,
		S_A_RD, S_A_GAIN, S_A_DIV, S_A_WAIT
	} state_t;

	state_t state_q;

	logic [6:0]  vol_q;
	logic [15:0] amp_q;
	logic        mute_q;
	logic        norm_q;
	logic [23:0] maxl_q;
	logic [3:0]  cc_q;

	logic [avn_pkg::CH_W-1:0]    ch_q;
	logic                        neg_q;
	logic [23:0]                 mag_q;
	logic                        last_q;
	logic                        normon_q;
	logic                        active_q;
	logic [avn_pkg::CNT_W-1:0]   cl_q;
	logic [avn_pkg::SLOT_W-1:0]  slot_q;
	logic [avn_pkg::HIST_AW-1:0] clr_q;
	logic [46:0]                 sq_q;
	logic [avn_pkg::TOT_W-1:0]   tot_q;
	logic [avn_pkg::LVL_W-1:0]   old_q;
	logic [avn_pkg::SQ_OUT_W-1:0] lvl_q;
	logic [avn_pkg::TOT_W-1:0]   totn_q;
	logic [23:0]                 avg_q;
	logic [avn_pkg::GAIN_W-1:0]  gain_q;
	logic [39:0]                 p1_q;
	logic [46:0]                 p2_q;
	logic [42:0]                 den_q;
	logic                        done_q;
	logic [23:0]                 sample_q;
	logic [2:0]                  chout_q;
	logic                        clip_q;

	logic [avn_pkg::CNT_W-1:0]   n_act;
	logic [23:0]                 lim;
	logic [6:0]                  vol_eff;
	logic [15:0]                 amp_eff;
	logic [23:0]                 mag_in;
	logic [avn_pkg::CH_W-1:0]    cl_idx;
	logic [avn_pkg::HIST_AW-1:0] hist_idx;
	logic [avn_pkg::SUM_W:0]     sum_add;
	logic [avn_pkg::SUM_W-1:0]   sum_sat;
	logic [58:0]                 avg_prod;
	logic [avn_pkg::GAIN_W-1:0]  gain_sel;

	logic                        chan_we;
	logic [avn_pkg::CH_W-1:0]    chan_addr;
	avn_pkg::chan_entry_t        chan_wdata;
	avn_pkg::chan_entry_t        chan_rdata;
	logic                        hist_we;
	logic [avn_pkg::HIST_AW-1:0] hist_addr;
	logic [avn_pkg::LVL_W-1:0]   hist_wdata;
	logic [avn_pkg::LVL_W-1:0]   hist_rdata;

	logic                        sq_start;
	logic                        sq_done;
	logic [avn_pkg::SQ_OUT_W-1:0] sq_root;
	logic                        dv_start;
	logic [avn_pkg::DIVD_W-1:0]  dv_dividend;
	logic [avn_pkg::DIVS_W-1:0]  dv_divisor;
	logic                        dv_done;
	logic [avn_pkg::QUO_W-1:0]   dv_q;

	assign busy        = state_q != S_IDLE;
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign sample_out  = sample_q;
	assign channel_out = chout_q;
	assign clipped     = clip_q;

	assign n_act   = (cc_q > 4'(avn_pkg::MAX_CH)) ? avn_pkg::CNT_W'(avn_pkg::MAX_CH)
		: avn_pkg::CNT_W'(cc_q);
	assign lim     = (maxl_q < avn_pkg::MIN_LEVEL) ? avn_pkg::MIN_LEVEL : maxl_q;
	assign vol_eff = (vol_q > avn_pkg::VOL_MAX) ? avn_pkg::VOL_MAX : vol_q;
	assign amp_eff = mute_q ? 16'd0 : ((amp_q > avn_pkg::AMP_MAX) ? avn_pkg::AMP_MAX : amp_q);
	assign mag_in  = sample_in[23] ? 24'(25'h1000000 - 25'({1'b0, sample_in})) : sample_in;
	assign cl_idx  = cl_q[avn_pkg::CH_W-1:0];
	assign hist_idx = avn_pkg::HIST_AW'(32'(cl_idx) * avn_pkg::HIST_DEPTH)
		+ avn_pkg::HIST_AW'(slot_q);
	assign sum_add = {1'b0, chan_rdata.sum} + (avn_pkg::SUM_W + 1)'(sq_q);
	assign sum_sat = sum_add[avn_pkg::SUM_W] ? '1 : sum_add[avn_pkg::SUM_W-1:0];
	assign avg_prod = 32'(totn_q[avn_pkg::TOT_W-1:2]) * avn_pkg::RECIP5;
	assign gain_sel = (normon_q && active_q && chan_rdata.gain != '0) ? chan_rdata.gain
		: avn_pkg::UNITY_Q16;

	always_comb begin
		chan_we    = 1'b0;
		chan_addr  = ch_q;
		chan_wdata = chan_rdata;
		hist_we    = 1'b0;
		hist_addr  = hist_idx;
		hist_wdata = avn_pkg::LVL_W'(lvl_q);
		if (state_q inside {S_C_RD, S_C_LOAD, S_C_SQ, S_C_TOT, S_C_AVG, S_C_CMP,
			S_C_DIV, S_C_WR}) begin
			chan_addr = cl_idx;
		end
		case (state_q)
			S_CLEAR: begin
				chan_addr  = clr_q[avn_pkg::CH_W-1:0];
				chan_we    = clr_q < avn_pkg::HIST_AW'(avn_pkg::MAX_CH);
				chan_wdata = '{sum: '0, tot: '0, gain: avn_pkg::UNITY_Q16};
				hist_addr  = clr_q;
				hist_we    = 1'b1;
				hist_wdata = '0;
			end
			S_M_ADD: begin
				chan_we        = 1'b1;
				chan_wdata.sum = sum_sat;
			end
			S_C_TOT: begin
				hist_we = 1'b1;
			end
			S_C_WR: begin
				chan_we    = 1'b1;
				chan_wdata = '{sum: '0, tot: totn_q, gain: gain_q};
			end
			default: begin
			end
		endcase
	end

	assign sq_start = state_q == S_C_LOAD;
	assign dv_start = (state_q == S_A_DIV) || (state_q == S_C_CMP && avg_q > lim);
	assign dv_dividend = (state_q == S_A_DIV) ? {p2_q, 17'b0} + avn_pkg::DIVD_W'(den_q)
		: avn_pkg::DIVD_W'({avg_q, 16'b0});
	assign dv_divisor  = (state_q == S_A_DIV) ? avn_pkg::DIVS_W'({den_q, 1'b0})
		: avn_pkg::DIVS_W'(lim);

	avn_ram #(.WIDTH(avn_pkg::CHAN_W), .DEPTH(avn_pkg::MAX_CH)) u_chan_ram (
		.clk   (clk),
		.we    (chan_we),
		.addr  (chan_addr),
		.wdata (chan_wdata),
		.rdata (chan_rdata)
	);

	avn_ram #(.WIDTH(avn_pkg::LVL_W), .DEPTH(avn_pkg::HIST_N)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.addr  (hist_addr),
		.wdata (hist_wdata),
		.rdata (hist_rdata)
	);

	avn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (chan_rdata.sum[avn_pkg::SUM_W-1:14]),
		.done     (sq_done),
		.root     (sq_root)
	);

	avn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (dv_start),
		.dividend (dv_dividend),
		.divisor  (dv_divisor),
		.done     (dv_done),
		.quotient (dv_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			clr_q    <= '0;
			slot_q   <= '0;
			cl_q     <= '0;
			done_q   <= 1'b0;
			clip_q   <= 1'b0;
			vol_q    <= 7'd100;
			amp_q    <= 16'd4096;
			mute_q   <= 1'b0;
			norm_q   <= 1'b0;
			maxl_q   <= 24'd131072;
			cc_q     <= 4'd2;
		end else begin
			done_q <= 1'b0;
			clip_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					avn_pkg::CFG_VOLUME:    vol_q  <= cfg_data[6:0];
					avn_pkg::CFG_PREAMP:    amp_q  <= cfg_data[15:0];
					avn_pkg::CFG_MUTE:      mute_q <= cfg_data[0];
					avn_pkg::CFG_NORMALIZE: norm_q <= cfg_data[0];
					avn_pkg::CFG_MAX_LEVEL: maxl_q <= cfg_data;
					avn_pkg::CFG_CH_COUNT:  cc_q   <= cfg_data[3:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == avn_pkg::HIST_AW'(avn_pkg::HIST_N - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						ch_q     <= channel;
						neg_q    <= sample_in[23];
						mag_q    <= mag_in;
						last_q   <= buffer_end;
						normon_q <= norm_q && !mute_q;
						active_q <= avn_pkg::CNT_W'(channel) < n_act;
						cl_q     <= '0;
						if (kind) begin
							state_q <= S_A_RD;
						end else if (norm_q && !mute_q) begin
							if (avn_pkg::CNT_W'(channel) < n_act) begin
								state_q <= S_M_RD;
							end else if (buffer_end) begin
								state_q <= S_C_RD;
							end
						end
					end
				end
				S_M_RD: begin
					sq_q    <= 47'(mag_q * mag_q);
					state_q <= S_M_ADD;
				end
				S_M_ADD: begin
					state_q <= last_q ? S_C_RD : S_IDLE;
				end
				S_C_RD: begin
					if (cl_q >= n_act) begin
						slot_q  <= (slot_q == avn_pkg::SLOT_W'(avn_pkg::HIST_DEPTH - 1)) ? '0
							: slot_q + 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_C_LOAD;
					end
				end
				S_C_LOAD: begin
					tot_q   <= chan_rdata.tot;
					old_q   <= hist_rdata;
					state_q <= S_C_SQ;
				end
				S_C_SQ: begin
					if (sq_done) begin
						lvl_q   <= sq_root;
						state_q <= S_C_TOT;
					end
				end
				S_C_TOT: begin
					totn_q  <= tot_q - avn_pkg::TOT_W'(old_q) + avn_pkg::TOT_W'(lvl_q);
					state_q <= S_C_AVG;
				end
				S_C_AVG: begin
					avg_q   <= 24'(avg_prod >> 34);
					state_q <= S_C_CMP;
				end
				S_C_CMP: begin
					if (avg_q > lim) begin
						state_q <= S_C_DIV;
					end else begin
						gain_q  <= avn_pkg::UNITY_Q16;
						state_q <= S_C_WR;
					end
				end
				S_C_DIV: begin
					if (dv_done) begin
						gain_q  <= (dv_q > avn_pkg::QUO_W'(avn_pkg::GAIN_MAX)) ? avn_pkg::GAIN_MAX
							: avn_pkg::GAIN_W'(dv_q);
						state_q <= S_C_WR;
					end
				end
				S_C_WR: begin
					cl_q    <= cl_q + 1'b1;
					state_q <= S_C_RD;
				end
				S_A_RD: begin
					p1_q    <= 40'(mag_q * amp_eff);
					state_q <= S_A_GAIN;
				end
				S_A_GAIN: begin
					p2_q    <= 47'(p1_q * vol_eff);
					den_q   <= 43'(avn_pkg::DEN_SCALE * gain_sel);
					state_q <= S_A_DIV;
				end
				S_A_DIV: begin
					state_q <= S_A_WAIT;
				end
				S_A_WAIT: begin
					if (dv_done) begin
						done_q  <= 1'b1;
						chout_q <= ch_q;
						if (neg_q) begin
							if (dv_q > 32'h800000) begin
								sample_q <= 24'h800000;
								clip_q   <= 1'b1;
							end else begin
								sample_q <= 24'(33'h1000000 - 33'(dv_q));
							end
						end else begin
							if (dv_q > 32'h7FFFFF) begin
								sample_q <= 24'h7FFFFF;
								clip_q   <= 1'b1;
							end else begin
								sample_q <= dv_q[23:0];
							end
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`AVN_ASSERT_CLK(a_done_after_div, done |-> $past(state_q) == S_A_WAIT, "strobe without divide")
	`AVN_ASSERT_IMPL(a_clip_with_strobe, clipped, done, "clipped outside strobe")
	`AVN_ASSERT_CLK(a_slot_range, slot_q < avn_pkg::SLOT_W'(avn_pkg::HIST_DEPTH), "slot out of range")
	`AVN_ASSERT_IMPL(a_no_write_idle, state_q == S_IDLE, !chan_we && !hist_we, "write while idle")

endmodule
